FILE: hdl/bcd_frequency_codec_core_assert.svh
// Assertion macros shared by the codec RTL; empty when SYNTHESIS is defined.
`ifndef BCD_FREQUENCY_CODEC_CORE_ASSERT_SVH
`define BCD_FREQUENCY_CODEC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfc assertion failed");
`define BFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfc assertion failed");
`else
`define BFC_ASSERT_SAME(label, ante, cons)
`define BFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/bfc_pkg.sv
// Shared constants and the per-cell stage type of the BCD frequency codec.
package bfc_pkg;

  localparam int BCD_BYTES  = 4;
  localparam int MAX_DIGITS = 16;
  localparam int DIGITS     = (2 * BCD_BYTES > MAX_DIGITS) ? MAX_DIGITS : 2 * BCD_BYTES;
  localparam int WORD_W     = 4 * DIGITS;

  localparam int BIN_IN_W  = 27;
  localparam int BCD_IN_W  = 32;
  localparam int BCD_OUT_W = 32;
  localparam int BIN_OUT_W = 28;
  localparam int NIB_W     = 4;

  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 64;

  // value / 10 == (value * RECIP10) >> RECIP_SHIFT for any 32-bit value
  localparam int          RECIP_W     = 32;
  localparam int          PROD_W      = BIN_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [NIB_W-1:0] DEC_BASE = 4'd10;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [BIN_IN_W-1:0]  value;  // encode: remaining quotient
    logic [WORD_W-1:0]    acc;    // encode: digits shifted in from the top
    logic [WORD_W-1:0]    word;   // decode: nibbles still to consume, top first
    logic [BIN_OUT_W-1:0] sum;    // decode: running weighted sum
  } stage_t;

endpackage

FILE: hdl/bfc_cell.sv
// One digit cell: a divide-by-ten step for encode and a multiply-add step for decode.
module bfc_cell
  import bfc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  `include "bcd_frequency_codec_core_assert.svh"

  logic                 valid;
  stage_t               data;
  stage_t               data_next;
  logic [PROD_W-1:0]    prod;
  logic [BIN_IN_W-1:0]  quot;
  logic [BIN_IN_W-1:0]  ten_quot;
  logic [BIN_IN_W-1:0]  rem;
  logic [NIB_W-1:0]     digit;
  logic [NIB_W-1:0]     nib;

  assign prod     = PROD_W'(up_data.value) * PROD_W'(RECIP10);
  assign quot     = BIN_IN_W'(prod >> RECIP_SHIFT);
  assign ten_quot = BIN_IN_W'({quot, 3'b000}) + BIN_IN_W'({quot, 1'b0});
  assign rem      = up_data.value - ten_quot;
  assign digit    = rem[NIB_W-1:0];
  assign nib      = up_data.word[WORD_W-1 -: NIB_W];

  always_comb begin
    data_next       = up_data;
    data_next.value = quot;
    data_next.acc   = {digit, up_data.acc[WORD_W-1:NIB_W]};
    data_next.word  = up_data.word << NIB_W;
    data_next.sum   = BIN_OUT_W'({up_data.sum, 3'b000}) + BIN_OUT_W'({up_data.sum, 1'b0})
                      + BIN_OUT_W'(nib);
  end

  // register frees up whenever its beat leaves this cycle
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

  `BFC_ASSERT_SAME(a_digit_range, up_valid, (digit < DEC_BASE) && (rem < BIN_IN_W'(DEC_BASE)))
  `BFC_ASSERT_NEXT(a_hold_on_stall, valid && !dn_ready, valid && $stable(data))
  `BFC_ASSERT_NEXT(a_load_on_accept, up_valid && up_ready, valid)

endmodule

FILE: hdl/bcd_frequency_codec_core.sv
// Top level of the packed BCD <-> binary frequency codec: a chain of digit cells.
//
// Input channel s_*: one beat per conversion. s_tuser is the kind (0 encodes
// binary_in to packed BCD, 1 decodes bcd_in to binary). Output channel m_*:
// exactly one result beat per input beat, in order. Encode fills bcd_out with
// the low eight decimal digits and raises wrapped (m_tuser) when higher digits
// were dropped; decode fills binary_out with the weighted sum of all nibbles,
// nibbles 10 to 15 taken at face value. Unused result fields read as zero.
// Each digit cell registers the beat in turn, and the last cell drives m_tvalid.
// Throughput is one beat per cycle while m_tready is high: each cell does one
// divide-by-ten (reciprocal multiply) or one multiply-by-ten add per cycle.
// Each cell stalls only while its own beat is blocked, so bubbles close up
// and s_tready stays high until the chain is full behind a stalled receiver;
// the last cell serves as the output register. Reset clears every cell's
// valid bit; no result is pending afterward.
module bcd_frequency_codec_core
  import bfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // binary_in[26:0], bcd_in[58:27], zero pad
  input  logic                s_tuser,   // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // bcd_out[31:0], binary_out[59:32], zero pad
  output logic                m_tuser    // wrapped
);

  logic   valid [DIGITS+1];
  logic   ready [DIGITS+1];
  stage_t data  [DIGITS+1];

  logic [BIN_IN_W-1:0]  binary_in;
  logic [BCD_IN_W-1:0]  bcd_in;
  logic [BCD_OUT_W-1:0] bcd_out;
  logic [BIN_OUT_W-1:0] binary_out;
  logic                 wrapped;
  logic                 is_decode;

  assign binary_in = s_tdata[BIN_IN_W-1:0];
  assign bcd_in    = s_tdata[BIN_IN_W +: BCD_IN_W];

  assign valid[0]      = s_tvalid;
  assign s_tready      = ready[0];
  assign data[0].kind  = s_tuser;
  assign data[0].value = binary_in;
  assign data[0].acc   = '0;
  assign data[0].word  = WORD_W'(bcd_in);
  assign data[0].sum   = '0;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    bfc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[i]),
      .up_ready (ready[i]),
      .up_data  (data[i]),
      .dn_valid (valid[i+1]),
      .dn_ready (ready[i+1]),
      .dn_data  (data[i+1])
    );
  end

  assign ready[DIGITS] = m_tready;

  assign is_decode  = (data[DIGITS].kind == KIND_DECODE);
  assign bcd_out    = is_decode ? '0 : BCD_OUT_W'(data[DIGITS].acc);
  assign binary_out = is_decode ? data[DIGITS].sum : '0;
  // any quotient left after the last cell means digits above those kept
  assign wrapped    = !is_decode && (data[DIGITS].value != '0);

  assign m_tvalid = valid[DIGITS];
  assign m_tdata  = M_DATA_W'({binary_out, bcd_out});
  assign m_tuser  = wrapped;

endmodule
